// ===== hdl/timed_job_sorted_queue_assert.svh =====
// assertion helpers used by the queue sequencer
`ifndef TIMED_JOB_SORTED_QUEUE_ASSERT_SVH
`define TIMED_JOB_SORTED_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TJSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TJSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tjsq_pkg.sv =====
`timescale 1ns / 1ps

package tjsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 8;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // one stored job
  typedef struct packed {
    logic [TIME_W-1:0]   due_time;
    logic [TAG_BITS-1:0] tag;
    logic                skip;
    logic                ask;
  } entry_t;

  // one incoming transaction
  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   due_time;
    logic [TAG_BITS-1:0] job_tag;
    logic                skip_trash;
    logic                ask_first;
  } item_t;

  // one outgoing transaction
  typedef struct packed {
    logic                popped_valid;
    logic [TIME_W-1:0]   popped_time;
    logic [TAG_BITS-1:0] popped_tag;
    logic                popped_skip;
    logic                popped_ask;
    logic                overflow;
    logic                queue_empty;
    logic [CNT_W-1:0]    entry_count;
  } result_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/tjsq_if.sv =====
`timescale 1ns / 1ps

// input channel
interface tjsq_in_if;
  import tjsq_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [TIME_W-1:0]   due_time;
  logic [TAG_BITS-1:0] job_tag;
  logic                skip_trash;
  logic                ask_first;

  modport source (output valid, func, due_time, job_tag, skip_trash, ask_first,
                  input ready);
  modport sink (input valid, func, due_time, job_tag, skip_trash, ask_first,
                output ready);
endinterface

// result channel
interface tjsq_out_if;
  import tjsq_pkg::*;

  logic                valid;
  logic                ready;
  logic                popped_valid;
  logic [TIME_W-1:0]   popped_time;
  logic [TAG_BITS-1:0] popped_tag;
  logic                popped_skip;
  logic                popped_ask;
  logic                overflow;
  logic                queue_empty;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, popped_valid, popped_time, popped_tag, popped_skip,
                  popped_ask, overflow, queue_empty, entry_count,
                  input ready);
  modport sink (input valid, popped_valid, popped_time, popped_tag, popped_skip,
                popped_ask, overflow, queue_empty, entry_count,
                output ready);
endinterface

// ===== hdl/tjsq_store.sv =====
`timescale 1ns / 1ps

module tjsq_store (
  input  logic               clk,
  input  tjsq_pkg::mem_req_t req,
  output tjsq_pkg::entry_t   rdata
);
  import tjsq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tjsq_seq.sv =====
`timescale 1ns / 1ps
`include "timed_job_sorted_queue_assert.svh"

module tjsq_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tjsq_pkg::item_t    in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output tjsq_pkg::result_t  res_data,
  output tjsq_pkg::mem_req_t mem_req,
  input  tjsq_pkg::entry_t   mem_rdata
);
  import tjsq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_WALK  = 6'b000010,
    S_INS_LAST  = 6'b000100,
    S_POP_HEAD  = 6'b001000,
    S_POP_SHIFT = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  entry_t           new_r, new_nxt;
  logic             pvalid_r, pvalid_nxt;
  entry_t           pentry_r, pentry_nxt;
  logic             ovf_r, ovf_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic             full;
  logic             empty;
  logic             earlier;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  // insert compare: stored entry strictly earlier than the new job
  assign earlier = (mem_rdata.due_time < new_r.due_time);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // result fields, count already updated when in the done state
  always_comb begin
    res_data.popped_valid = pvalid_r;
    res_data.popped_time  = pentry_r.due_time;
    res_data.popped_tag   = pentry_r.tag;
    res_data.popped_skip  = pentry_r.skip;
    res_data.popped_ask   = pentry_r.ask;
    res_data.overflow     = ovf_r;
    res_data.queue_empty  = empty;
    res_data.entry_count  = count_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    new_nxt       = new_r;
    pvalid_nxt    = pvalid_r;
    pentry_nxt    = pentry_r;
    ovf_nxt       = ovf_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = new_r;
    mem_req.raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.due_time = in_item.due_time;
          new_nxt.tag      = in_item.job_tag;
          new_nxt.skip     = in_item.skip_trash;
          new_nxt.ask      = in_item.ask_first;
          pvalid_nxt       = 1'b0;
          pentry_nxt       = '0;
          ovf_nxt          = 1'b0;
          case (in_item.func)
            FUNC_INSERT: begin
              if (full) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else if (empty) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = new_nxt;
                count_nxt     = CNT_W'(1);
                state_nxt     = S_DONE;
              end else begin
                mem_req.raddr = cnt_m1[IDX_W-1:0];
                idx_nxt       = cnt_m1[IDX_W-1:0];
                state_nxt     = S_INS_WALK;
              end
            end
            FUNC_POP: begin
              if (empty) begin
                state_nxt = S_DONE;
              end else begin
                mem_req.raddr = '0;
                idx_nxt       = '0;
                state_nxt     = S_POP_HEAD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // walk from the tail, moving later-or-equal entries up one slot
      S_INS_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r + IDX_W'(1);
        if (earlier) begin
          mem_req.wdata = new_r;
          count_nxt     = count_r + CNT_W'(1);
          state_nxt     = S_DONE;
        end else begin
          mem_req.wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            mem_req.raddr = idx_r - IDX_W'(1);
            idx_nxt       = idx_r - IDX_W'(1);
          end
        end
      end

      // new job becomes the head
      S_INS_LAST: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = new_r;
        count_nxt     = count_r + CNT_W'(1);
        state_nxt     = S_DONE;
      end

      // head arrives from memory
      S_POP_HEAD: begin
        pvalid_nxt = 1'b1;
        pentry_nxt = mem_rdata;
        if (count_r == CNT_W'(1)) begin
          count_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          mem_req.raddr = IDX_W'(1);
          idx_nxt       = IDX_W'(1);
          state_nxt     = S_POP_SHIFT;
        end
      end

      // move each remaining entry down one slot
      S_POP_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r - IDX_W'(1);
        mem_req.wdata = mem_rdata;
        if (CNT_W'(idx_r) == cnt_m1) begin
          count_nxt = cnt_m1;
          state_nxt = S_DONE;
        end else begin
          mem_req.raddr = idx_r + IDX_W'(1);
          idx_nxt       = idx_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    new_r    <= new_nxt;
    pvalid_r <= pvalid_nxt;
    pentry_r <= pentry_nxt;
    ovf_r    <= ovf_nxt;
  end

  // walk index stays inside the filled region
  `TJSQ_ASSERT_IMPLY(a_walk_in_range, clk, rst_n, (state_r == S_INS_WALK), (CNT_W'(idx_r) < count_r), "insert walk index beyond fill count")
  // shifting only happens with at least two entries
  `TJSQ_ASSERT_IMPLY(a_shift_count, clk, rst_n, (state_r == S_POP_SHIFT), (count_r >= CNT_W'(2)), "pop shift with fewer than two entries")
  // insert into a full queue is dropped with overflow
  `TJSQ_ASSERT_NEXT(a_full_drop, clk, rst_n, (state_r == S_IDLE && in_valid && in_item.func == FUNC_INSERT && full), (state_r == S_DONE && ovf_r && $stable(count_r)), "full insert not flagged as overflow")

endmodule

// ===== hdl/timed_job_sorted_queue.sv =====
`timescale 1ns / 1ps
// flow: an insert into an empty or full queue, or a pop of an empty one, goes straight from
//   idle to the done state; otherwise an insert walks from the tail and a pop shifts the
//   remaining entries, one entry per cycle through the memory port
// throughput: one transaction at a time, the next one accepted once the sequencer is idle
// reset: synchronous active-low rst_n clears fill count, sequencer and output valid;
//   stored entries are left as they are and are never read before being written

module timed_job_sorted_queue (
  input  logic clk,
  input  logic rst_n,
  tjsq_in_if.sink    in_ch,
  tjsq_out_if.source out_ch
);
  import tjsq_pkg::*;

  item_t    in_item;
  result_t  res_data;
  logic     res_valid;
  logic     res_ready;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  logic     out_valid_r, out_valid_nxt;
  result_t  out_r, out_nxt;

  // gather the input payload
  always_comb begin
    in_item.func       = in_ch.func;
    in_item.due_time   = in_ch.due_time;
    in_item.job_tag    = in_ch.job_tag;
    in_item.skip_trash = in_ch.skip_trash;
    in_item.ask_first  = in_ch.ask_first;
  end

  tjsq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tjsq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // drive the result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_valid = out_r.popped_valid;
  assign out_ch.popped_time  = out_r.popped_time;
  assign out_ch.popped_tag   = out_r.popped_tag;
  assign out_ch.popped_skip  = out_r.popped_skip;
  assign out_ch.popped_ask   = out_r.popped_ask;
  assign out_ch.overflow     = out_r.overflow;
  assign out_ch.queue_empty  = out_r.queue_empty;
  assign out_ch.entry_count  = out_r.entry_count;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tjsq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic clk;
  logic rst_n;

  tjsq_in_if  in_ch ();
  tjsq_out_if out_ch ();

  timed_job_sorted_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the sorted job list
  entry_t  model_jobs [QUEUE_DEPTH+1];
  int      model_fill;
  result_t pending_outcomes [$];

  int  failures;
  int  cycles;
  bit  idle_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // apply one transaction to the shadow list and return the outcome it causes
  function automatic result_t queue_step(input item_t job);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (job.func == FUNC_INSERT) begin
      if (model_fill >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        e.due_time = job.due_time;
        e.tag      = job.job_tag;
        e.skip     = job.skip_trash;
        e.ask      = job.ask_first;
        // goes ahead of the first entry that is not strictly earlier
        pos = 0;
        while (pos < model_fill && model_jobs[pos].due_time < e.due_time) pos++;
        for (int i = model_fill; i > pos; i--) model_jobs[i] = model_jobs[i-1];
        model_jobs[pos] = e;
        model_fill++;
      end
    end else if (model_fill > 0) begin
      r.popped_valid = 1'b1;
      r.popped_time  = model_jobs[0].due_time;
      r.popped_tag   = model_jobs[0].tag;
      r.popped_skip  = model_jobs[0].skip;
      r.popped_ask   = model_jobs[0].ask;
      for (int i = 1; i < model_fill; i++) model_jobs[i-1] = model_jobs[i];
      model_fill--;
    end
    r.queue_empty = (model_fill == 0);
    r.entry_count = model_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("valid=%0d time=%h tag=%h skip=%0d ask=%0d ovf=%0d empty=%0d count=%0d",
                     r.popped_valid, r.popped_time, r.popped_tag, r.popped_skip,
                     r.popped_ask, r.overflow, r.queue_empty, r.entry_count);
  endfunction

  function automatic item_t make_insert(input logic [TIME_W-1:0] t,
                                        input logic [TAG_BITS-1:0] tag,
                                        input logic skip, input logic ask);
    item_t job;
    job.func       = FUNC_INSERT;
    job.due_time   = t;
    job.job_tag    = tag;
    job.skip_trash = skip;
    job.ask_first  = ask;
    return job;
  endfunction

  // pop with random noise on the unused payload
  function automatic item_t make_pop();
    item_t job;
    job.func       = FUNC_POP;
    job.due_time   = $urandom();
    job.job_tag    = TAG_BITS'($urandom());
    job.skip_trash = 1'($urandom_range(0, 1));
    job.ask_first  = 1'($urandom_range(0, 1));
    return job;
  endfunction

  // due times: extremes, a narrow band for ties, and the full range
  function automatic logic [TIME_W-1:0] pick_due_time();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t random_insert();
    return make_insert(pick_due_time(), TAG_BITS'($urandom()),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // send one transaction, with an occasional idle burst before it
  task automatic send_job(input item_t job);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= job.func;
    in_ch.due_time   <= job.due_time;
    in_ch.job_tag    <= job.job_tag;
    in_ch.skip_trash <= job.skip_trash;
    in_ch.ask_first  <= job.ask_first;
    do @(posedge clk); while (!in_ch.ready);
    pending_outcomes.push_back(queue_step(job));
  endtask

  // stop sending and wait until every outcome has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest outcome awaited
  initial failures = 0;
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.popped_valid, out_ch.popped_time, out_ch.popped_tag, out_ch.popped_skip,
             out_ch.popped_ask, out_ch.overflow, out_ch.queue_empty, out_ch.entry_count};
      if (pending_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch expected: %s", fmt_result(want));
            $display("mismatch actual:   %s", fmt_result(got));
          end
        end
      end
    end
  end

  // pops on an empty queue right after reset
  task automatic test_empty_pop();
    send_job(make_pop());
    send_job(make_pop());
  endtask

  // ordering by due time, newest first among ties, field extremes
  task automatic test_ordering();
    send_job(make_insert(32'd100, 8'h01, 1'b0, 1'b0));
    send_job(make_insert(32'd0, 8'h00, 1'b1, 1'b1));
    send_job(make_insert(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0));
    send_job(make_insert(32'd100, 8'hAA, 1'b0, 1'b1));
    send_job(make_insert(32'd50, 8'h55, 1'b1, 1'b1));
    send_job(make_insert(32'd100, 8'h5A, 1'b0, 1'b0));
    send_job(make_insert(32'hFFFF_FFFF, 8'hC3, 1'b0, 1'b1));
    repeat (8) send_job(make_pop());
  endtask

  // fill to near or past full so some inserts overflow, then drain to empty or past it
  task automatic test_fill_overflow();
    int n_ins;
    int n_pop;
    repeat (10) begin
      n_ins = $urandom_range(14, 20);
      repeat (n_ins) send_job(random_insert());
      n_pop = model_fill + $urandom_range(0, 2);
      repeat (n_pop) send_job(make_pop());
    end
  endtask

  // mixed traffic in blocks of varying insert bias
  task automatic test_random_mix();
    int bias;
    repeat (18) begin
      case ($urandom_range(0, 3))
        0:       bias = 30;
        1:       bias = 50;
        2:       bias = 70;
        default: bias = 85;
      endcase
      repeat (50) begin
        if ($urandom_range(0, 99) < bias) send_job(random_insert());
        else send_job(make_pop());
      end
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (400) begin
      if ($urandom_range(0, 99) < 55) send_job(random_insert());
      else send_job(make_pop());
    end
  endtask

  // main sequence
  initial begin
    model_fill = 0;
    idle_on    = 1'b1;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_INSERT;
    in_ch.due_time   <= '0;
    in_ch.job_tag    <= '0;
    in_ch.skip_trash <= 1'b0;
    in_ch.ask_first  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pop();
    test_ordering();
    wait_drained();
    test_fill_overflow();
    test_random_mix();
    wait_drained();
    test_steady_stream();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
